@@ hw/rtl/wnsf_pkg.sv @@
// wnsf_pkg: types, constants and helper functions of the warped noise shaping filter
// no dependencies; used by wnsf_state_ram, wnsf_core and warped_noise_shaping_filter
package wnsf_pkg;

  localparam int MAX_ORDER  = 16;
  localparam int ADDR_W     = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
  localparam int NUM_COEF   = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int MAX_EVEN   = MAX_ORDER & -2;

  localparam logic [CFG_IDX_W-1:0] CFG_ORDER  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WARP   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TILT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_0 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_1 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_2 = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_3 = 3'd6;

  localparam logic [4:0] ORDER_RST = 5'd16;

  typedef struct packed {
    logic        [4:0]               order;
    logic signed [15:0]              warp;
    logic signed [15:0]              tilt;
    logic        [NUM_COEF-1:0][15:0] coef;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TILT,
    ST_WARP,
    ST_UPD,
    ST_COEF,
    ST_FIN,
    ST_DONE
  } state_t;

  // index of the last section in use: order made even and clamped to [2, MAX_EVEN], minus one
  function automatic logic [ADDR_W-1:0] last_sec(logic [4:0] order);
    int n;
    n = int'(order) & -2;
    if (n < 2) n = 2;
    if (n > MAX_EVEN) n = MAX_EVEN;
    return ADDR_W'(n - 1);
  endfunction

  function automatic logic signed [15:0] coef_at(logic [NUM_COEF-1:0][15:0] c,
                                                 logic [ADDR_W-1:0] k);
    int i;
    i = int'(k);
    if (i >= NUM_COEF) return 16'sd0;
    return $signed(c[i[3:0]]);
  endfunction

endpackage

@@ hw/rtl/wnsf_state_ram.sv @@
// wnsf_state_ram: allpass state memory, one read and one write port, registered read
// depends on wnsf_pkg; entries never written since reset read as zero
module wnsf_state_ram (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      rd_en,
  input  logic [wnsf_pkg::ADDR_W-1:0] rd_addr,
  output logic [31:0]               rd_data,
  input  logic                      wr_en,
  input  logic [wnsf_pkg::ADDR_W-1:0] wr_addr,
  input  logic [31:0]               wr_data
);

  logic [31:0]                  mem [wnsf_pkg::MAX_ORDER];
  logic [wnsf_pkg::MAX_ORDER-1:0] vld_r;
  logic [31:0]                  rdat_r;
  logic                         rvld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdat_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      rvld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rvld_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_data = rvld_r ? rdat_r : 32'd0;

endmodule

@@ hw/rtl/wnsf_core.sv @@
// wnsf_core: section sequencer, shared 32x16 multiplier, accumulator and result register
// depends on wnsf_pkg and wnsf_state_ram
module wnsf_core (
  input  logic                clk,
  input  logic                rst_n,
  input  wnsf_pkg::cfg_t      cfg,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic signed [31:0]  in_history_sample,
  input  logic signed [31:0]  in_low_freq_value,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [31:0]  out_shaping_feedback
);

  localparam int AW = wnsf_pkg::ADDR_W;

  wnsf_pkg::state_t state_r, state_nxt;

  logic [AW-1:0]       k_r, k_nxt;
  logic [AW-1:0]       last_k;
  logic signed [31:0]  lf_r, lf_nxt;
  logic signed [31:0]  old_r, old_nxt;
  logic signed [31:0]  yprev_r, yprev_nxt;
  logic signed [31:0]  sold_r, sold_nxt;
  logic signed [31:0]  diff_r, diff_nxt;
  logic signed [31:0]  acc_r, acc_nxt;
  logic signed [31:0]  tilt_r, tilt_nxt;
  logic signed [47:0]  prod_r, prod_nxt;
  logic signed [31:0]  prod_hi;
  logic signed [31:0]  mul_a;
  logic signed [15:0]  mul_b;
  logic                ovld_r, ovld_nxt;
  logic signed [31:0]  odat_r, odat_nxt;
  logic signed [31:0]  y_new;

  logic                rd_en;
  logic [AW-1:0]       rd_addr;
  logic [31:0]         rd_data;
  logic                wr_en;

  wnsf_state_ram u_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (k_r),
    .wr_data (y_new)
  );

  assign last_k  = wnsf_pkg::last_sec(cfg.order);
  assign prod_hi = prod_r[47:16];
  assign y_new   = old_r + prod_hi;

  // operand select for the shared multiplier
  always_comb begin
    case (state_r)
      wnsf_pkg::ST_TILT: begin
        mul_a = lf_r;
        mul_b = cfg.tilt;
      end
      wnsf_pkg::ST_COEF: begin
        mul_a = yprev_r;
        mul_b = wnsf_pkg::coef_at(cfg.coef, k_r);
      end
      default: begin
        mul_a = diff_r;
        mul_b = cfg.warp;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wnsf_pkg::ST_IDLE;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r     <= k_nxt;
    lf_r    <= lf_nxt;
    old_r   <= old_nxt;
    yprev_r <= yprev_nxt;
    sold_r  <= sold_nxt;
    diff_r  <= diff_nxt;
    acc_r   <= acc_nxt;
    tilt_r  <= tilt_nxt;
    prod_r  <= prod_nxt;
    odat_r  <= odat_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    lf_nxt    = lf_r;
    old_nxt   = old_r;
    yprev_nxt = yprev_r;
    sold_nxt  = sold_r;
    diff_nxt  = diff_r;
    acc_nxt   = acc_r;
    tilt_nxt  = tilt_r;
    prod_nxt  = prod_r;
    odat_nxt  = odat_r;
    ovld_nxt  = ovld_r && out_stall;
    in_stall  = 1'b1;
    rd_en     = 1'b0;
    rd_addr   = k_r + AW'(1);
    wr_en     = 1'b0;
    case (state_r)
      wnsf_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        rd_addr  = '0;
        if (in_valid) begin
          rd_en     = 1'b1;
          k_nxt     = '0;
          lf_nxt    = in_low_freq_value;
          old_nxt   = in_history_sample;
          yprev_nxt = 32'sd0;
          acc_nxt   = 32'sd0;
          state_nxt = wnsf_pkg::ST_TILT;
        end
      end
      wnsf_pkg::ST_TILT: begin
        prod_nxt  = mul_a * mul_b;
        diff_nxt  = $signed(rd_data) - yprev_r;
        sold_nxt  = $signed(rd_data);
        state_nxt = wnsf_pkg::ST_WARP;
      end
      wnsf_pkg::ST_WARP: begin
        prod_nxt = mul_a * mul_b;
        rd_en    = (k_r != last_k);
        if (k_r == '0) begin
          tilt_nxt = prod_hi;
        end else begin
          acc_nxt = acc_r + prod_hi;
        end
        state_nxt = wnsf_pkg::ST_UPD;
      end
      wnsf_pkg::ST_UPD: begin
        wr_en     = 1'b1;
        yprev_nxt = y_new;
        old_nxt   = sold_r;
        state_nxt = wnsf_pkg::ST_COEF;
      end
      wnsf_pkg::ST_COEF: begin
        prod_nxt = mul_a * mul_b;
        diff_nxt = $signed(rd_data) - yprev_r;
        sold_nxt = $signed(rd_data);
        if (k_r == last_k) begin
          state_nxt = wnsf_pkg::ST_FIN;
        end else begin
          k_nxt     = k_r + AW'(1);
          state_nxt = wnsf_pkg::ST_WARP;
        end
      end
      wnsf_pkg::ST_FIN: begin
        acc_nxt   = acc_r + prod_hi;
        state_nxt = wnsf_pkg::ST_DONE;
      end
      wnsf_pkg::ST_DONE: begin
        if (!(ovld_r && out_stall)) begin
          odat_nxt  = {acc_r[31], acc_r[31:1]} + tilt_r;
          ovld_nxt  = 1'b1;
          state_nxt = wnsf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = wnsf_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid            = ovld_r;
  assign out_shaping_feedback = odat_r;

endmodule

@@ hw/rtl/warped_noise_shaping_filter.sv @@
// warped_noise_shaping_filter: top level, configuration registers and filter core
// depends on wnsf_pkg and wnsf_core
// one transaction at a time: input stalled until its result is built; each section takes one
//   state RAM read-modify-write and two passes through the shared multiplier
// reset: state memory reads as zero, order 16, other configuration registers zero, no result pending
module warped_noise_shaping_filter (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [31:0]                   in_history_sample,
  input  logic signed [31:0]                   in_low_freq_value,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [31:0]                   out_shaping_feedback,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [wnsf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [wnsf_pkg::CFG_DATA_W-1:0]      cfg_data
);

  wnsf_pkg::cfg_t cfg_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.order <= wnsf_pkg::ORDER_RST;
      cfg_r.warp  <= '0;
      cfg_r.tilt  <= '0;
      cfg_r.coef  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        wnsf_pkg::CFG_ORDER: cfg_r.order <= cfg_data[4:0];
        wnsf_pkg::CFG_WARP:  cfg_r.warp  <= $signed(cfg_data[15:0]);
        wnsf_pkg::CFG_TILT:  cfg_r.tilt  <= $signed(cfg_data[15:0]);
        wnsf_pkg::CFG_COEF_0: cfg_r.coef[3:0]   <= cfg_data;
        wnsf_pkg::CFG_COEF_1: cfg_r.coef[7:4]   <= cfg_data;
        wnsf_pkg::CFG_COEF_2: cfg_r.coef[11:8]  <= cfg_data;
        wnsf_pkg::CFG_COEF_3: cfg_r.coef[15:12] <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  wnsf_core u_core (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg                  (cfg_r),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_history_sample    (in_history_sample),
    .in_low_freq_value    (in_low_freq_value),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_shaping_feedback (out_shaping_feedback)
  );

  // one transaction in flight: an accepted item blocks the input until its result is built
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken again right after a transaction");

  // a new result only appears after the input side was busy computing it
  a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a computation");

  // a taken result is followed by another only if the input was stalled when it was taken
  a_no_phantom_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall) |=> (!out_valid || $past(in_stall)))
    else $error("result produced without input");

endmodule
